// ===== src/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Operation codes, the per-cell pipeline record and the clamp/arctangent
// helpers used by the front end, the cells and the back end.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4,
		OP_MOD  = 3'd5,
		OP_ARG  = 3'd6
	} op_t;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam int CORDIC_STEPS = 60;
	localparam int SQRT_STEPS = 32;

	// One beat as it travels down the row of cells.
	typedef struct packed {
		op_t                op;
		logic [31:0]        res_re;
		logic [31:0]        res_im;
		logic               sat;
		logic               dz;
		logic               x_neg;
		logic               y_neg;
		logic               a_zero;
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic signed [63:0] cz;
		logic [63:0]        den;
		logic [63:0]        dr_re;
		logic [63:0]        dr_im;
		logic [31:0]        dq_re;
		logic [31:0]        dq_im;
		logic               dv_re;
		logic               dv_im;
		logic               dn_re;
		logic               dn_im;
		logic [63:0]        sq_rad;
		logic [35:0]        sq_rem;
		logic [31:0]        sq_root;
	} cell_t;

	// atan(2^-i) in Q60 from its power series, evaluated at elaboration.
	function automatic logic signed [63:0] atan_q60(input int i);
		logic signed [63:0] sum;
		logic [63:0] term;
		int e;
		sum = '0;
		if (i == 0) begin
			return signed'(PI_Q60 >> 2);
		end
		for (int k = 0; k < 64; k++) begin
			e = 60 - i * (2 * k + 1);
			if (e >= 0) begin
				term = (64'd1 << e) / 64'(2 * k + 1);
				if (k[0]) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
		end
		return sum;
	endfunction

	// Clamp a sign/magnitude value to the signed ew-bit range.
	// Returns {saturated, value sign-extended to 32 bits}.
	function automatic logic [32:0] clamp_mag(input logic neg, input logic [64:0] mag,
			input int ew);
		logic [64:0] lim;
		logic [64:0] val;
		logic sat;
		lim = 65'd1 << (ew - 1);
		sat = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				sat = 1'b1;
				val = -lim;
			end else begin
				val = -mag;
			end
		end else begin
			if (mag > lim - 65'd1) begin
				sat = 1'b1;
				val = lim - 65'd1;
			end else begin
				val = mag;
			end
		end
		return {sat, val[31:0]};
	endfunction

endpackage
`default_nettype wire

// ===== src/complex_arith_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit: complex-number arithmetic on signed fixed point
// Add, subtract, multiply, divide, conjugate, modulus and argument.
// Every operation passes through four front stages, one cell per
// CORDIC rotation (60 cells, which also run the divide and square-root steps),
// and two result stages. A new operation is taken every cycle; busy stays low.
// Reset clears all valid flags; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	output logic             done,
	output logic [31:0]      res_real,
	output logic [31:0]      res_imag,
	output logic             div_zero,
	output logic             saturated
);

	localparam int EW = (WORD_BITS > 32) ? 32 : WORD_BITS;

	logic  accept;
	logic  chain_v [0:CORDIC_STEPS];
	cell_t chain_c [0:CORDIC_STEPS];

	assign busy = 1'b0;
	assign accept = start & ~busy;

	cau_front #(
		.FRAC_BITS(FRAC_BITS),
		.EW(EW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.operation(operation),
		.a_real(a_real),
		.a_imag(a_imag),
		.b_real(b_real),
		.b_imag(b_imag),
		.out_valid(chain_v[0]),
		.out_c(chain_c[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		cau_cell #(
			.STEP(i),
			.QB(EW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(chain_v[i]),
			.in_c(chain_c[i]),
			.out_valid(chain_v[i+1]),
			.out_c(chain_c[i+1])
		);
	end

	cau_back #(
		.FRAC_BITS(FRAC_BITS),
		.EW(EW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(chain_v[CORDIC_STEPS]),
		.in_c(chain_c[CORDIC_STEPS]),
		.done(done),
		.res_real(res_real),
		.res_imag(res_imag),
		.div_zero(div_zero),
		.saturated(saturated)
	);

endmodule
`default_nettype wire

// ===== src/cau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front: operand capture, products and cell setup
// Registers the beat, forms the partial products, finishes add, subtract,
// conjugate and multiply, and prepares the divide, square root and CORDIC
// operands for the row of cells.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int EW = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	output logic             out_valid,
	output cell_t            out_c
);

	localparam int PAD = 32 - EW;
	localparam int QB = EW;
	localparam int NW = 64 + FRAC_BITS;
	localparam logic [64:0] HALF_F = 65'd1 << (FRAC_BITS - 1);

	function automatic logic signed [31:0] sext(input logic [31:0] v);
		logic signed [31:0] t;
		t = signed'(v << PAD);
		return t >>> PAD;
	endfunction

	function automatic logic [32:0] clamp_s33(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : 33'(v);
		return clamp_mag(v[32], 65'(m), EW);
	endfunction

	// Stage 1: captured operands.
	logic               v_s1;
	op_t                op_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			op_s1 <= op_t'(operation);
			ar_s1 <= sext(a_real);
			ai_s1 <= sext(a_imag);
			br_s1 <= sext(b_real);
			bi_s1 <= sext(b_imag);
		end
	end

	// Stage 2: products, simple results, first normalizing shifts.
	logic signed [63:0] p0, p1, p2, p3, p4, p5;
	logic [32:0]        cl_re, cl_im;
	logic [63:0]        ax, ay, nx16, ny16, nx32, ny32;
	logic [31:0]        abs_r, abs_i;

	assign p0 = ar_s1 * br_s1;
	assign p1 = ai_s1 * bi_s1;
	assign p2 = ar_s1 * bi_s1;
	assign p3 = ai_s1 * br_s1;
	assign p4 = (op_s1 == OP_MOD) ? ar_s1 * ar_s1 : br_s1 * br_s1;
	assign p5 = (op_s1 == OP_MOD) ? ai_s1 * ai_s1 : bi_s1 * bi_s1;

	always_comb begin
		case (op_s1)
			OP_ADD: begin
				cl_re = clamp_s33(33'(ar_s1) + 33'(br_s1));
				cl_im = clamp_s33(33'(ai_s1) + 33'(bi_s1));
			end
			OP_SUB: begin
				cl_re = clamp_s33(33'(ar_s1) - 33'(br_s1));
				cl_im = clamp_s33(33'(ai_s1) - 33'(bi_s1));
			end
			OP_CONJ: begin
				cl_re = clamp_s33(33'(ar_s1));
				cl_im = clamp_s33(-33'(ai_s1));
			end
			default: begin
				cl_re = '0;
				cl_im = '0;
			end
		endcase
	end

	always_comb begin
		abs_r = ar_s1[31] ? 32'(-ar_s1) : 32'(ar_s1);
		abs_i = ai_s1[31] ? 32'(-ai_s1) : 32'(ai_s1);
		ax = 64'(abs_r);
		ay = 64'(abs_i);
		// Shift up until the larger magnitude reaches bit 59.
		if (ax < (64'd1 << 28) && ay < (64'd1 << 28)) begin
			nx32 = ax << 32;
			ny32 = ay << 32;
		end else begin
			nx32 = ax;
			ny32 = ay;
		end
		if (nx32 < (64'd1 << 44) && ny32 < (64'd1 << 44)) begin
			nx16 = nx32 << 16;
			ny16 = ny32 << 16;
		end else begin
			nx16 = nx32;
			ny16 = ny32;
		end
	end

	logic               v_s2;
	op_t                op_s2;
	logic signed [63:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic [31:0]        re_s2, im_s2;
	logic               sat_s2, xn_s2, yn_s2, az_s2;
	logic [63:0]        nx_s2, ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		p0_s2  <= p0;
		p1_s2  <= p1;
		p2_s2  <= p2;
		p3_s2  <= p3;
		p4_s2  <= p4;
		p5_s2  <= p5;
		re_s2  <= cl_re[31:0];
		im_s2  <= cl_im[31:0];
		sat_s2 <= cl_re[32] | cl_im[32];
		xn_s2  <= ar_s1[31];
		yn_s2  <= ai_s1[31];
		az_s2  <= (ar_s1 == '0) && (ai_s1 == '0);
		nx_s2  <= nx16;
		ny_s2  <= ny16;
	end

	// Stage 3: sign/magnitude numerators, the squared-magnitude sum, further normalizing shifts.
	logic signed [65:0] num_re, num_im, abs_re, abs_im;
	logic [63:0]        den, nx8, ny8, nx4, ny4;

	always_comb begin
		if (op_s2 == OP_MUL) begin
			num_re = 66'(p0_s2) - 66'(p1_s2);
			num_im = 66'(p2_s2) + 66'(p3_s2);
		end else begin
			num_re = 66'(p0_s2) + 66'(p1_s2);
			num_im = 66'(p3_s2) - 66'(p2_s2);
		end
		abs_re = num_re[65] ? -num_re : num_re;
		abs_im = num_im[65] ? -num_im : num_im;
		den = 64'($unsigned(p4_s2)) + 64'($unsigned(p5_s2));
		if (nx_s2 < (64'd1 << 52) && ny_s2 < (64'd1 << 52)) begin
			nx8 = nx_s2 << 8;
			ny8 = ny_s2 << 8;
		end else begin
			nx8 = nx_s2;
			ny8 = ny_s2;
		end
		if (nx8 < (64'd1 << 56) && ny8 < (64'd1 << 56)) begin
			nx4 = nx8 << 4;
			ny4 = ny8 << 4;
		end else begin
			nx4 = nx8;
			ny4 = ny8;
		end
	end

	logic        v_s3;
	op_t         op_s3;
	logic [63:0] mre_s3, mim_s3, den_s3, nx_s3, ny_s3;
	logic        nre_s3, nim_s3;
	logic [31:0] re_s3, im_s3;
	logic        sat_s3, xn_s3, yn_s3, az_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		mre_s3 <= abs_re[63:0];
		mim_s3 <= abs_im[63:0];
		nre_s3 <= num_re[65];
		nim_s3 <= num_im[65];
		den_s3 <= den;
		re_s3  <= re_s2;
		im_s3  <= im_s2;
		sat_s3 <= sat_s2;
		xn_s3  <= xn_s2;
		yn_s3  <= yn_s2;
		az_s3  <= az_s2;
		nx_s3  <= nx4;
		ny_s3  <= ny4;
	end

	// Stage 4: multiply rounding, divide setup, last normalizing shifts.
	logic [64:0]    rnd_re, rnd_im;
	logic [32:0]    mc_re, mc_im;
	logic [NW-1:0]  n_re, n_im, nh_re, nh_im;
	logic [63:0]    nx2, ny2, nx1, ny1;
	cell_t          c;

	always_comb begin
		rnd_re = (65'(mre_s3) + HALF_F) >> FRAC_BITS;
		rnd_im = (65'(mim_s3) + HALF_F) >> FRAC_BITS;
		mc_re = clamp_mag(nre_s3, rnd_re, EW);
		mc_im = clamp_mag(nim_s3, rnd_im, EW);
		n_re = (NW'(mre_s3) << FRAC_BITS) + NW'(den_s3 >> 1);
		n_im = (NW'(mim_s3) << FRAC_BITS) + NW'(den_s3 >> 1);
		nh_re = n_re >> QB;
		nh_im = n_im >> QB;
		if (nx_s3 < (64'd1 << 58) && ny_s3 < (64'd1 << 58)) begin
			nx2 = nx_s3 << 2;
			ny2 = ny_s3 << 2;
		end else begin
			nx2 = nx_s3;
			ny2 = ny_s3;
		end
		if (nx2 < (64'd1 << 59) && ny2 < (64'd1 << 59)) begin
			nx1 = nx2 << 1;
			ny1 = ny2 << 1;
		end else begin
			nx1 = nx2;
			ny1 = ny2;
		end

		c = '0;
		c.op = op_s3;
		c.x_neg = xn_s3;
		c.y_neg = yn_s3;
		c.a_zero = az_s3;
		c.cx = signed'(nx1);
		c.cy = signed'(ny1);
		c.cz = '0;
		c.den = den_s3;
		c.dr_re = nh_re[63:0];
		c.dr_im = nh_im[63:0];
		c.dq_re = 32'(n_re[QB-1:0]) << (32 - QB);
		c.dq_im = 32'(n_im[QB-1:0]) << (32 - QB);
		c.dv_re = nh_re >= NW'(den_s3);
		c.dv_im = nh_im >= NW'(den_s3);
		c.dn_re = nre_s3;
		c.dn_im = nim_s3;
		c.sq_rad = den_s3;
		case (op_s3)
			OP_MUL: begin
				c.res_re = mc_re[31:0];
				c.res_im = mc_im[31:0];
				c.sat = mc_re[32] | mc_im[32];
			end
			OP_DIV: begin
				c.dz = (den_s3 == '0);
			end
			default: begin
				c.res_re = re_s3;
				c.res_im = im_s3;
				c.sat = sat_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_c <= c;
	end

endmodule
`default_nettype wire

// ===== src/cau_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_cell: one step of the iterative row
// Performs one CORDIC vectoring rotation, a restoring divide step for both quotients
// (STEP < QB) and a square-root digit (STEP < SQRT_STEPS), then hands the beat on.
// ----------------------------------------------------------------------------
module cau_cell import cau_pkg::*; #(
	parameter int STEP = 0,
	parameter int QB = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire cell_t in_c,
	output logic       out_valid,
	output cell_t      out_c
);

	localparam logic signed [63:0] ATAN = atan_q60(STEP);

	cell_t c;

	always_comb begin
		logic signed [63:0] x, y;
		logic [64:0] rs_re, rs_im;
		logic ge_re, ge_im;
		logic [35:0] rn, trial;
		x = in_c.cx;
		y = in_c.cy;
		c = in_c;

		if (!y[63]) begin
			c.cx = x + (y >>> STEP);
			c.cy = y - (x >>> STEP);
			c.cz = in_c.cz + ATAN;
		end else begin
			c.cx = x - (y >>> STEP);
			c.cy = y + (x >>> STEP);
			c.cz = in_c.cz - ATAN;
		end

		rs_re = {in_c.dr_re, in_c.dq_re[31]};
		rs_im = {in_c.dr_im, in_c.dq_im[31]};
		ge_re = rs_re >= 65'(in_c.den);
		ge_im = rs_im >= 65'(in_c.den);
		if (STEP < QB) begin
			c.dr_re = ge_re ? 64'(rs_re - 65'(in_c.den)) : rs_re[63:0];
			c.dr_im = ge_im ? 64'(rs_im - 65'(in_c.den)) : rs_im[63:0];
			c.dq_re = {in_c.dq_re[30:0], ge_re};
			c.dq_im = {in_c.dq_im[30:0], ge_im};
		end

		rn = {in_c.sq_rem[33:0], in_c.sq_rad[63:62]};
		trial = {2'b00, in_c.sq_root, 2'b01};
		if (STEP < SQRT_STEPS) begin
			c.sq_rad = in_c.sq_rad << 2;
			if (rn >= trial) begin
				c.sq_rem = rn - trial;
				c.sq_root = {in_c.sq_root[30:0], 1'b1};
			end else begin
				c.sq_rem = rn;
				c.sq_root = {in_c.sq_root[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_c <= c;
	end

endmodule
`default_nettype wire

// ===== src/cau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back: result assembly
// Rounds and clamps the quotients, the square root and the angle, selects
// the result for the operation and drives the registered result beat.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int EW = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire cell_t in_c,
	output logic        done,
	output logic [31:0] res_real,
	output logic [31:0] res_imag,
	output logic        div_zero,
	output logic        saturated
);

	localparam int SH = 60 - FRAC_BITS;
	localparam logic [63:0] HALF_A = 64'd1 << (SH - 1);
	localparam logic [63:0] HALF_PI = PI_Q60 >> 1;
	localparam logic [63:0] TWO_PI = PI_Q60 << 1;
	localparam logic [63:0] TQ = (TWO_PI + HALF_A) >> SH;

	// Stage 1: quotient and root clamps, quadrant mapping of the angle.
	logic [63:0] zc, t;
	logic [32:0] root, sc, dc_re, dc_im;
	logic [31:0] re, im;
	logic        sat;

	always_comb begin
		if (in_c.cz[63]) begin
			zc = '0;
		end else if ($unsigned(in_c.cz) > HALF_PI) begin
			zc = HALF_PI;
		end else begin
			zc = $unsigned(in_c.cz);
		end
		if (in_c.x_neg) begin
			t = in_c.y_neg ? PI_Q60 + zc : PI_Q60 - zc;
		end else begin
			t = in_c.y_neg ? TWO_PI - zc : zc;
		end

		// The remainder exceeds the root exactly when the fraction is past one half.
		root = 33'(in_c.sq_root) + 33'(in_c.sq_rem > 36'(in_c.sq_root));
		sc = clamp_mag(1'b0, 65'(root), EW);
		dc_re = clamp_mag(in_c.dn_re, in_c.dv_re ? '1 : 65'(in_c.dq_re), EW);
		dc_im = clamp_mag(in_c.dn_im, in_c.dv_im ? '1 : 65'(in_c.dq_im), EW);

		case (in_c.op)
			OP_DIV: begin
				if (in_c.dz) begin
					re = in_c.res_re;
					im = in_c.res_im;
					sat = in_c.sat;
				end else begin
					re = dc_re[31:0];
					im = dc_im[31:0];
					sat = dc_re[32] | dc_im[32];
				end
			end
			OP_MOD: begin
				re = sc[31:0];
				im = '0;
				sat = sc[32];
			end
			default: begin
				re = in_c.res_re;
				im = in_c.res_im;
				sat = in_c.sat;
			end
		endcase
	end

	logic        v_s1;
	op_t         op_s1;
	logic [31:0] re_s1, im_s1;
	logic        sat_s1, dz_s1, az_s1;
	logic [63:0] t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= in_c.op;
		re_s1  <= re;
		im_s1  <= im;
		sat_s1 <= sat;
		dz_s1  <= in_c.dz;
		az_s1  <= in_c.a_zero;
		t_s1   <= t;
	end

	// Stage 2: angle rounding; a value that rounds to a full turn, or a zero operand, gives zero.
	logic [63:0] q;
	logic [32:0] ac;

	always_comb begin
		q = (t_s1 + HALF_A) >> SH;
		if (az_s1 || q >= TQ) begin
			q = '0;
		end
		ac = clamp_mag(1'b0, 65'(q), EW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_zero <= dz_s1;
		if (op_s1 == OP_ARG) begin
			res_real  <= ac[31:0];
			res_imag  <= '0;
			saturated <= ac[32];
		end else begin
			res_real  <= re_s1;
			res_imag  <= im_s1;
			saturated <= sat_s1;
		end
	end

endmodule
`default_nettype wire
